>>> src/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

>>> src/bch1511_pkg.sv
package bch1511_pkg;

	localparam int unsigned WORD_W = 30;
	localparam int unsigned TDATA_W = 32;
	localparam int unsigned CW_W = 15;
	localparam int unsigned REG_W = 4;
	localparam int unsigned SPLIT = 8;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [CW_W-1:0] cw_t;
	typedef logic [REG_W-1:0] synreg_t;

	typedef struct packed {
		logic adv_s2;
		logic adv_s3;
		logic first_s2;
	} bch1511_lane_ctl_t;

	// all stages start at -1, held as negative flags
	localparam synreg_t REG_INIT = 4'b1111;

	localparam logic [3:0] ERR_POS [CW_W] = '{
		4'd14, 4'd13, 4'd10, 4'd12, 4'd6, 4'd9, 4'd4, 4'd11,
		4'd0, 4'd5, 4'd7, 4'd8, 4'd1, 4'd3, 4'd2
	};

	// one shift of the sign-domain syndrome register
	function automatic synreg_t syn_step(input synreg_t r, input logic sym);
		synreg_t n;
		logic fb;
		fb = r[3];
		n[3] = r[2];
		n[2] = r[1];
		n[1] = r[0] ^ fb;
		n[0] = ~sym ^ fb;
		return n;
	endfunction

endpackage

>>> src/bch15_11_word_decoder.sv
// bch(15,11) word decoder, two codeword lanes and a merging output register
// an accepted item is registered in s1, s2 and s3 and then in the output register
// throughput: one item per cycle while m_tready holds, set by the four-stage bubble-collapsing pipeline
// reset: arst_n clears all stage valid flags at once, no clearing pass
`include "assert_macros.svh"

module bch15_11_word_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [29:0] received_bits, [31:30] zero
	input  logic        s_tuser,  // [0] first_word
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata   // [29:0] decoded_bits, [31:30] zero
);
	import bch1511_pkg::*;

	logic v_s1, v_s2, v_s3;
	logic first_s1, first_s2, first_s3;
	cw_t  a_s1, b_s1, a_s3, b_s3;
	logic en1, en2, en3, en_out;
	word_t word;
	bch1511_lane_ctl_t ctl;

	assign en3 = !v_s3 || en_out;
	assign en2 = !v_s2 || en3;
	assign en1 = !v_s1 || en2;
	assign s_tready = en1;

	assign ctl.adv_s2 = en2;
	assign ctl.adv_s3 = en3;
	assign ctl.first_s2 = first_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (en1) begin
				v_s1 <= s_tvalid;
			end
			if (en2) begin
				v_s2 <= v_s1;
			end
			if (en3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// deinterleave into the two codewords
	always_ff @(posedge clk) begin
		if (en1) begin
			first_s1 <= s_tuser;
			for (int c = 0; c < CW_W; c++) begin
				a_s1[c] <= s_tdata[2*c];
				b_s1[c] <= s_tdata[2*c+1];
			end
		end
		if (en2) begin
			first_s2 <= first_s1;
		end
		if (en3) begin
			first_s3 <= first_s2;
		end
	end

	bch1511_lane u_lane_a (
		.clk   (clk),
		.ctl   (ctl),
		.cw_s1 (a_s1),
		.cw_s3 (a_s3)
	);

	bch1511_lane u_lane_b (
		.clk   (clk),
		.ctl   (ctl),
		.cw_s1 (b_s1),
		.cw_s3 (b_s3)
	);

	bch1511_merge u_merge (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s3 (v_s3),
		.first_s3 (first_s3),
		.a_s3     (a_s3),
		.b_s3     (b_s3),
		.adv      (en_out),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.word     (word)
	);

	assign m_tdata = {(TDATA_W - WORD_W)'(0), word};

	// full pipeline with a stalled output refuses new items
	`ASSERT_IMPL(a_full_stall, clk, arst_n, v_s1 && v_s2 && v_s3 && m_tvalid && !m_tready, !s_tready)
	// an item in stage one moves on when stage two frees up
	`ASSERT_NEXT(a_s1_moves, clk, arst_n, v_s1 && en2, v_s2)
	// an item in stage three reaches the output register
	`ASSERT_NEXT(a_s3_to_out, clk, arst_n, v_s3 && en_out, m_tvalid)

endmodule

>>> src/bch1511_lane.sv
module bch1511_lane (
	input  logic                           clk,
	input  bch1511_pkg::bch1511_lane_ctl_t ctl,
	input  bch1511_pkg::cw_t               cw_s1,
	output bch1511_pkg::cw_t               cw_s3
);
	import bch1511_pkg::*;

	synreg_t reg_s2;
	cw_t     cw_s2;
	synreg_t reg_mid;
	synreg_t reg_end;
	synreg_t syn;
	cw_t     fixed;

	// first SPLIT symbol steps (8 of the 15)
	always_comb begin
		reg_mid = REG_INIT;
		for (int i = 0; i < SPLIT; i++) begin
			reg_mid = syn_step(reg_mid, cw_s1[i]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv_s2) begin
			reg_s2 <= reg_mid;
			cw_s2  <= cw_s1;
		end
	end

	// remaining steps, then single-bit correction, skipped on the first word
	always_comb begin
		reg_end = reg_s2;
		for (int i = SPLIT; i < CW_W; i++) begin
			reg_end = syn_step(reg_end, cw_s2[i]);
		end
		syn = ~reg_end;
		fixed = cw_s2;
		if (!ctl.first_s2 && (syn != '0)) begin
			fixed = cw_s2 ^ (cw_t'(1) << ERR_POS[4'(syn - 4'd1)]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.adv_s3) begin
			cw_s3 <= fixed;
		end
	end

endmodule

>>> src/bch1511_merge.sv
module bch1511_merge (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              valid_s3,
	input  logic              first_s3,
	input  bch1511_pkg::cw_t  a_s3,
	input  bch1511_pkg::cw_t  b_s3,
	output logic              adv,
	output logic              m_tvalid,
	input  logic              m_tready,
	output bch1511_pkg::word_t word
);
	import bch1511_pkg::*;

	logic  valid_q;
	word_t word_q;
	word_t merged;

	assign adv = !valid_q || m_tready;
	assign m_tvalid = valid_q;
	assign word = word_q;

	always_comb begin
		if (first_s3) begin
			// first word: restore the original symbol order
			for (int c = 0; c < CW_W; c++) begin
				merged[2*c]   = a_s3[c];
				merged[2*c+1] = b_s3[c];
			end
		end else begin
			merged = {b_s3[14:11], a_s3[14:11], b_s3[10:0], a_s3[10:0]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (adv) begin
			valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			word_q <= merged;
		end
	end

endmodule
